>>> sv/lsq_pkg.sv
// Shared types and constants for the largest square of ones block.
package lsq_pkg;

    localparam int SIZE_W    = 11;
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 10;
    localparam int CCNT_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd1;

    localparam logic [CCNT_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROW_W-1:0]  ROWS_RESET = 16'd1024;

    typedef struct packed {
        logic [SIZE_W-1:0]    largest_size;
        logic [ROW_W-1:0]     corner_row;
        logic [COL_OUT_W-1:0] corner_column;
    } t_result;

    typedef struct packed {
        logic    grid_end;
        t_result result;
    } t_core_status;

endpackage

>>> sv/lsq_in_if.sv
// Input channel: one grid cell per word.
interface lsq_in_if;
    logic valid;
    logic ready;
    logic cell_is_one;

    modport source (output valid, output cell_is_one, input ready);
    modport sink   (input valid, input cell_is_one, output ready);
endinterface

>>> sv/lsq_out_if.sv
// Output channel: one result word per grid.
interface lsq_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] largest_size;
    logic [15:0] corner_row;
    logic [9:0]  corner_column;

    modport source (output valid, output largest_size, output corner_row,
                    output corner_column, input ready);
    modport sink   (input valid, input largest_size, input corner_row,
                    input corner_column, output ready);
endinterface

>>> sv/lsq_row_buf.sv
// Previous-row size buffer: one write port, one registered read port with bypass.
module lsq_row_buf
    import lsq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [SIZE_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [SIZE_W-1:0]        o_rdata
);

    logic [SIZE_W-1:0] r_mem [DEPTH];
    logic [SIZE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/lsq_core.sv
// Square-size recurrence, raster counters and best-so-far tracking.
module lsq_core
    import lsq_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_cell,
    input  logic [CCNT_W-1:0]   i_cols,
    input  logic [ROW_W-1:0]    i_rows,
    output t_core_status        o_status
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int XW = 18;

    logic [CW-1:0]     r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SIZE_W-1:0] r_left, n_left;
    logic [SIZE_W-1:0] r_ul, n_ul;
    logic [SIZE_W-1:0] r_best, n_best;
    logic [ROW_W-1:0]  r_best_row, n_best_row;
    logic [CW-1:0]     r_best_col, n_best_col;

    logic [SIZE_W-1:0] rb_rdata;
    logic [SIZE_W-1:0] up, m, size;
    logic [XW-1:0]     cols_x, col_p1;
    logic [ROW_W:0]    rows_x, row_p1;
    logic              last_col, last_row, better;

    lsq_row_buf #(.DEPTH(MAX_COLUMNS)) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (i_fire),
        .i_waddr (r_col),
        .i_wdata (size),
        .i_raddr (n_col),
        .o_rdata (rb_rdata)
    );

    always_comb begin
        cols_x = XW'(i_cols);
        if (cols_x == '0) begin
            cols_x = XW'(1);
        end else if (cols_x > XW'(MAX_COLUMNS)) begin
            cols_x = XW'(MAX_COLUMNS);
        end
        rows_x = (ROW_W+1)'(i_rows);
        if (rows_x == '0) begin
            rows_x = (ROW_W+1)'(1);
        end
        col_p1   = XW'(r_col) + XW'(1);
        row_p1   = (ROW_W+1)'(r_row) + (ROW_W+1)'(1);
        last_col = col_p1 >= cols_x;
        last_row = row_p1 >= rows_x;

        up = (r_row == '0) ? '0 : rb_rdata;
        m  = r_ul;
        if (r_left < m) begin
            m = r_left;
        end
        if (up < m) begin
            m = up;
        end
        if (!i_cell) begin
            size = '0;
        end else if (r_row == '0 || r_col == '0) begin
            size = SIZE_W'(1);
        end else if (m < SIZE_SAT) begin
            size = m + SIZE_W'(1);
        end else begin
            size = m;
        end
        better = size > r_best;
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_left     = r_left;
        n_ul       = r_ul;
        n_best     = r_best;
        n_best_row = r_best_row;
        n_best_col = r_best_col;
        if (i_fire) begin
            if (better) begin
                n_best     = size;
                n_best_row = r_row;
                n_best_col = r_col;
            end
            if (last_col) begin
                n_col  = '0;
                n_left = '0;
                n_ul   = '0;
                if (last_row) begin
                    n_row      = '0;
                    n_best     = '0;
                    n_best_row = '0;
                    n_best_col = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col  = CW'(col_p1);
                n_left = size;
                n_ul   = up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_ul       <= '0;
            r_best     <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_left     <= n_left;
            r_ul       <= n_ul;
            r_best     <= n_best;
            r_best_row <= n_best_row;
            r_best_col <= n_best_col;
        end
    end

    // result reflects the cell being processed, before the grid clear
    always_comb begin
        o_status.grid_end = last_col && last_row;
        if (better) begin
            o_status.result.largest_size  = size;
            o_status.result.corner_row    = r_row;
            o_status.result.corner_column = COL_OUT_W'(r_col);
        end else begin
            o_status.result.largest_size  = r_best;
            o_status.result.corner_row    = r_best_row;
            o_status.result.corner_column = COL_OUT_W'(r_best_col);
        end
    end

    a_grid_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && last_col && last_row |=> r_row == '0 && r_col == '0 && r_best == '0)
        else $error("grid state not cleared after last cell");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_col) < XW'(MAX_COLUMNS))
        else $error("column counter beyond row buffer");

endmodule

>>> sv/largest_square_of_ones.sv
// Top level: config registers, input register, size core and result register.
//
//  channel   dir   handshake        payload
//  i_in      in    valid/ready      cell_is_one
//  o_out     out   valid/ready      largest_size, corner_row, corner_column
//  i_cfg_*   in    write enable     index 0 column_count, index 1 row_count
//
//  One cell per cycle sustained but for the grid-end stall below; a cell reaches
//  the size stage in the cycle after acceptance, and the grid result shows on o_out
//  the cycle after the last cell fires. Throughput is set by the combinational
//  recurrence and the row buffer read, which is addressed one column ahead.
//  Reset (synchronous, active low) clears counters, best and valids; row buffer
//  contents are left as they are. Input stalls only while the last cell of a
//  grid waits on a full, unaccepted result register.
module largest_square_of_ones
    import lsq_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lsq_in_if.sink               i_in,
    lsq_out_if.source            o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [CCNT_W-1:0] r_cols;
    logic [ROW_W-1:0]  r_rows;
    logic              r_in_valid;
    logic              r_in_cell;
    logic              r_out_valid;
    t_result           r_out;
    t_core_status      core_status;
    logic              fire, out_free, in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_COLUMN_COUNT: r_cols <= i_cfg_data[CCNT_W-1:0];
                CFG_ROW_COUNT:    r_rows <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && (!core_status.grid_end || out_free);
    assign in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_cell <= i_in.cell_is_one;
        end
    end

    lsq_core #(.MAX_COLUMNS(MAX_COLUMNS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cell   (r_in_cell),
        .i_cols   (r_cols),
        .i_rows   (r_rows),
        .o_status (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_status.grid_end) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_status.grid_end) begin
            r_out <= core_status.result;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.largest_size  = r_out.largest_size;
    assign o_out.corner_row    = r_out.corner_row;
    assign o_out.corner_column = r_out.corner_column;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && core_status.grid_end |=> r_out_valid)
        else $error("grid end did not load result register");

    a_zero_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.largest_size == '0 |->
            r_out.corner_row == '0 && r_out.corner_column == '0)
        else $error("empty grid reported a nonzero corner");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result word lost or changed");

    a_word_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && in_ready |=> r_in_valid)
        else $error("accepted cell word not held");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for largest_square_of_ones: grids in, best square out.
`timescale 1ns / 1ps

module tb_top;
    import lsq_pkg::*;

    localparam int MAX_COLS   = 1024;
    localparam int CYCLE_MAX  = 1_000_000;
    localparam int RAND_CELLS = 780;
    localparam int RAND_GRIDS = 10;
    localparam int TALL_ROWS  = 64;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    lsq_in_if  in_ch ();
    lsq_out_if out_ch ();

    largest_square_of_ones i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // grid model state
    logic [SIZE_W-1:0]    row_sizes [MAX_COLS];
    logic [CCNT_W-1:0]    cfg_cols;
    logic [ROW_W-1:0]     cfg_rows;
    logic [SIZE_W-1:0]    left_size;
    logic [SIZE_W-1:0]    upleft_size;
    logic [SIZE_W-1:0]    best_size;
    logic [ROW_W-1:0]     cur_row;
    logic [ROW_W-1:0]     best_row;
    logic [COL_OUT_W-1:0] best_col;
    int unsigned          cur_col;

    t_result     grid_best_q[$];
    t_result     oldest_best;
    int unsigned cells_sent;
    int unsigned grids_checked;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          no_idle;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic clear_grid_state;
        left_size   = '0;
        upleft_size = '0;
        cur_row     = '0;
        cur_col     = 0;
        best_size   = '0;
        best_row    = '0;
        best_col    = '0;
    endtask

    task automatic take_cell(input logic cell_bit);
        int unsigned       cols_eff;
        int unsigned       rows_eff;
        int unsigned       col;
        logic [SIZE_W-1:0] up;
        logic [SIZE_W-1:0] sz;
        cols_eff = (cfg_cols == 0) ? 1 : int'(cfg_cols);
        if (cols_eff > MAX_COLS)
            cols_eff = MAX_COLS;
        rows_eff = (cfg_rows == 0) ? 1 : int'(cfg_rows);
        col = cur_col;
        up  = (cur_row != 0) ? row_sizes[col] : '0;
        if (!cell_bit) begin
            sz = '0;
        end else if (cur_row == 0 || col == 0) begin
            sz = SIZE_W'(1);
        end else begin
            sz = upleft_size;
            if (left_size < sz)
                sz = left_size;
            if (up < sz)
                sz = up;
            if (sz != SIZE_SAT)
                sz = sz + SIZE_W'(1);
        end
        row_sizes[col] = sz;
        upleft_size    = up;
        left_size      = sz;
        if (sz > best_size) begin
            best_size = sz;
            best_row  = cur_row;
            best_col  = col[COL_OUT_W-1:0];
        end
        if (col + 1 >= cols_eff) begin
            cur_col     = 0;
            left_size   = '0;
            upleft_size = '0;
            if (cur_row + 1 >= rows_eff) begin
                grid_best_q.push_back('{best_size, best_row, best_col});
                clear_grid_state();
            end else begin
                cur_row = cur_row + ROW_W'(1);
            end
        end else begin
            cur_col = col + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_cols = COLS_RESET;
            cfg_rows = ROWS_RESET;
            clear_grid_state();
        end else begin
            if (in_ch.valid && in_ch.ready)
                take_cell(in_ch.cell_is_one);
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COLUMN_COUNT: cfg_cols = cfg_data[CCNT_W-1:0];
                    CFG_ROW_COUNT:    cfg_rows = cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (grid_best_q.size() == 0) begin
                $error("unexpected result word: size %0d row %0d column %0d",
                       out_ch.largest_size, out_ch.corner_row, out_ch.corner_column);
                mismatches++;
            end else begin
                oldest_best = grid_best_q.pop_front();
                grids_checked++;
                if (out_ch.largest_size !== oldest_best.largest_size) begin
                    $error("largest_size: expected %0d, got %0d",
                           oldest_best.largest_size, out_ch.largest_size);
                    mismatches++;
                end
                if (out_ch.corner_row !== oldest_best.corner_row) begin
                    $error("corner_row: expected %0d, got %0d",
                           oldest_best.corner_row, out_ch.corner_row);
                    mismatches++;
                end
                if (out_ch.corner_column !== oldest_best.corner_column) begin
                    $error("corner_column: expected %0d, got %0d",
                           oldest_best.corner_column, out_ch.corner_column);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk)
        out_ch.ready <= no_idle || ($urandom_range(99) >= 19);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("largest_square_of_ones test failed");
            $finish;
        end
    end

    task automatic send_cell(input logic cell_bit);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cell_is_one <= cell_bit;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        cells_sent++;
    endtask

    // cells go out LSB first
    task automatic send_pattern(input logic [31:0] bits, input int n);
        for (int k = 0; k < n; k++)
            send_cell(bits[k]);
    endtask

    task automatic send_grid(input int n, input int ones_pct);
        for (int k = 0; k < n; k++)
            send_cell($urandom_range(99) < ones_pct);
    endtask

    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (grid_best_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [CCNT_W-1:0] cols, input logic [ROW_W-1:0] rows);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COLUMN_COUNT;
        cfg_data  <= CFG_DAT_W'(cols);
        @(negedge i_clk);
        cfg_index <= CFG_ROW_COUNT;
        cfg_data  <= rows;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_tiny_grids;
        set_grid(1, 1);
        send_pattern(32'b0, 1);
        send_pattern(32'b1, 1);
        drain();
        // zero counts act as one
        set_grid(0, 0);
        send_pattern(32'b1, 1);
        drain();
        set_grid(3, 3);
        send_pattern(32'h1ff, 9);
        drain();
        // equal sizes later on must not move the corner
        set_grid(3, 2);
        send_pattern(32'b101010, 6);
        drain();
    endtask

    task automatic test_column_clamp;
        set_grid(CCNT_W'(2047), 1);
        for (int k = 0; k < MAX_COLS; k++)
            send_cell(k == MAX_COLS - 1);
        drain();
    endtask

    task automatic test_tall_grid;
        set_grid(1, ROW_W'(TALL_ROWS));
        for (int k = 0; k < TALL_ROWS; k++)
            send_cell(k == TALL_ROWS - 1);
        drain();
    endtask

    task automatic test_random_grids;
        int unsigned start;
        int unsigned grids;
        int unsigned cols;
        int unsigned rows;
        int unsigned pct;
        int unsigned reps;
        start = cells_sent;
        grids = 0;
        while (cells_sent - start < RAND_CELLS || grids < RAND_GRIDS) begin
            no_idle = (cells_sent - start >= 200) && (cells_sent - start < 500);
            cols = ($urandom_range(9) == 0) ? $urandom_range(32, 13) : $urandom_range(12, 0);
            rows = ($urandom_range(9) == 0) ? $urandom_range(20, 13) : $urandom_range(12, 0);
            case ($urandom_range(3))
                0:       pct = 50;
                1:       pct = 80;
                2:       pct = 95;
                default: pct = 100;
            endcase
            reps = $urandom_range(3, 1);
            set_grid(CCNT_W'(cols), ROW_W'(rows));
            if (cols == 0)
                cols = 1;
            if (rows == 0)
                rows = 1;
            repeat (reps) begin
                send_grid(cols * rows, pct);
                grids++;
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_COLUMN_COUNT;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.cell_is_one = 1'b0;
        out_ch.ready      = 1'b0;
        no_idle           = 1'b0;
        cells_sent        = 0;
        grids_checked     = 0;
        mismatches        = 0;
        cycle_count       = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_tiny_grids();
        test_column_clamp();
        test_tall_grid();
        test_random_grids();

        repeat (8) @(posedge i_clk);
        if (grid_best_q.size() != 0) begin
            $error("%0d grid results never arrived", grid_best_q.size());
            mismatches++;
        end
        $display("sent %0d cells over tiny, clamped-width, single-column and random grids",
                 cells_sent);
        $display("%0d results checked, %0d mismatches in %0d cycles",
                 grids_checked, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("largest_square_of_ones test passed");
        end else begin
            $display("largest_square_of_ones test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/lsq_pkg.sv
sv/lsq_in_if.sv
sv/lsq_out_if.sv
sv/lsq_row_buf.sv
sv/lsq_core.sv
sv/largest_square_of_ones.sv
tb/tb_top.sv
